// ----- rtl/core/gltc_pkg.sv -----
// ----------------------------------------------------------------------------
// gltc_pkg
// Shared sizes, register codes and types of the gray Laplace threshold
// counter: frame limits, field widths, window cell control and pixel flags.
// ----------------------------------------------------------------------------
package gltc_pkg;

  // Frame limits and the counter widths that follow from them
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration register widths
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int KERNEL_W     = 36;
  localparam int THR_W        = 16;
  localparam int OBJ_W        = 24;
  localparam int CFG_DATA_W   = 36;
  localparam int CFG_IDX_W    = 3;

  // Datapath widths
  localparam int GRAY_W  = 8;
  localparam int COEF_W  = 4;
  localparam int PSUM_W  = 15;
  localparam int EDGE_W  = 16;
  localparam int CNT_W   = 24;
  localparam int TAPS    = 3;
  localparam int RAM_W   = 2 * GRAY_W;

  // Gray conversion weights, Q8
  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd151;
  localparam logic [7:0] W_BLUE  = 8'd28;

  // Register reset values
  localparam logic [WIDTH_CFG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [HEIGHT_CFG_W-1:0] RST_HEIGHT = 13'd480;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH      = 3'd0,
    REG_IMAGE_HEIGHT     = 3'd1,
    REG_KERNEL_COEFS     = 3'd2,
    REG_EDGE_THRESHOLD   = 3'd3,
    REG_OBJECT_THRESHOLD = 3'd4
  } cfg_reg_t;

  // One window column: index 0 top row, 2 newest row
  typedef logic [TAPS-1:0][GRAY_W-1:0] pix_col_t;
  // Coefficients of one window column, same row order
  typedef logic [TAPS-1:0][COEF_W-1:0] coef_col_t;
  typedef logic signed [PSUM_W-1:0]    psum_t;

  // Window cell strobes
  typedef struct packed {
    logic shift;
    logic sum_load;
  } cell_ctl_t;

  // Per-pixel position flags that travel with the beat
  typedef struct packed {
    logic interior;
    logic border;
    logic done;
  } pix_flags_t;

endpackage

// ----- rtl/core/gltc_ram.sv -----
// ----------------------------------------------------------------------------
// gltc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/gltc_cell.sv -----
// ----------------------------------------------------------------------------
// gltc_cell
// One column of the 3x3 window: holds three gray pixels, hands them to the
// next cell on each shift and forms the weighted column sum.
// ----------------------------------------------------------------------------
module gltc_cell (
  input  logic                  clk,
  input  gltc_pkg::cell_ctl_t   ctl,
  input  gltc_pkg::pix_col_t    col_in,
  input  gltc_pkg::coef_col_t   coefs,
  output gltc_pkg::pix_col_t    col_out,
  output gltc_pkg::psum_t       psum
);
  import gltc_pkg::*;

  pix_col_t col_r;
  psum_t    psum_r;
  psum_t    psum_nxt;
  psum_t    prod [TAPS];

  // Hold the column, advance on shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_in;
    end
  end

  // Weight each pixel by its signed coefficient and add the column
  always_comb begin
    psum_nxt = '0;
    for (int f = 0; f < TAPS; f++) begin
      prod[f]  = $signed({{(PSUM_W-GRAY_W){1'b0}}, col_r[f]})
               * $signed({{(PSUM_W-COEF_W){coefs[f][COEF_W-1]}}, coefs[f]});
      psum_nxt = psum_nxt + prod[f];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_load) begin
      psum_r <= psum_nxt;
    end
  end

  assign col_out = col_r;
  assign psum    = psum_r;

endmodule

// ----- rtl/core/gray_laplace_threshold_count_top.sv -----
// ----------------------------------------------------------------------------
// gray_laplace_threshold_count_top
// RGB to gray, 3x3 edge filter, binarisation and black-pixel count per frame.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order while the output is not held
// back, and returns one result beat per pixel through four register stages.
// The rate is set by the line memory (one read and one write per accepted
// pixel, holding the two previous rows) and by the window cells, which shift
// one column per pixel. Edge results belong to the pixel one row and one
// column back; border pixels give no edge result but are counted as black
// when the edge threshold is not negative. The beat of the frame's last pixel
// carries tlast, the black count and the object flag, and the count then
// restarts. The user must write frame size and kernel through the cfg port
// only while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gray_laplace_threshold_count_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Pixel input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,  // red[7:0], green[15:8], blue[23:16]
  // Result output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [47:0]                        out_tdata, // edge_value[15:0], binary_pixel[16],
                                                        // object_found[17], black_count[41:18]
  output logic                               out_tuser, // edge_valid
  output logic                               out_tlast, // frame_done
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gltc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gltc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gltc_pkg::*;

  // Configuration registers
  logic [WIDTH_CFG_W-1:0]  width_r;
  logic [HEIGHT_CFG_W-1:0] height_r;
  logic [KERNEL_W-1:0]     kernel_r;
  logic signed [THR_W-1:0] thr_r;
  logic [OBJ_W-1:0]        obj_r;

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt, col_last;
  logic [ROW_W-1:0] row_r, row_nxt, row_last;
  logic             last_col, last_row;
  pix_flags_t       flags_in;

  // Pipeline valids and loads
  logic v1_r, v2_r, v3_r, vo_r;
  logic load1, load2, load3, load_o, accept;

  // Stage 1
  logic [GRAY_W-1:0] red_s1_r, green_s1_r, blue_s1_r;
  logic [COL_W-1:0]  addr_s1_r;
  pix_flags_t        flags_s1_r, flags_s2_r, flags_s3_r;
  logic [15:0]       gray_acc;
  logic [GRAY_W-1:0] gray_s1;

  // Line memory
  logic              ram_we, ram_re;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  // Window cells
  cell_ctl_t cell_ctl;
  pix_col_t  cell_in  [TAPS];
  pix_col_t  cell_out [TAPS];
  coef_col_t cell_coef[TAPS];
  psum_t     cell_sum [TAPS];

  // Output stage
  logic signed [EDGE_W-1:0] edge_sum;
  logic                     bin_nxt;
  logic [1:0]               inc;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W-1:0]         black_r;
  logic                     edge_valid_o_r, bin_o_r, done_o_r, found_o_r;
  logic [EDGE_W-1:0]        edge_o_r;
  logic [CNT_W-1:0]         count_o_r;

  // Configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      kernel_r <= '0;
      thr_r    <= '0;
      obj_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:      width_r  <= cfg_data[WIDTH_CFG_W-1:0];
        REG_IMAGE_HEIGHT:     height_r <= cfg_data[HEIGHT_CFG_W-1:0];
        REG_KERNEL_COEFS:     kernel_r <= cfg_data[KERNEL_W-1:0];
        REG_EDGE_THRESHOLD:   thr_r    <= cfg_data[THR_W-1:0];
        REG_OBJECT_THRESHOLD: obj_r    <= cfg_data[OBJ_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range, as last indexes
  always_comb begin
    if (width_r < WIDTH_CFG_W'(3)) begin
      col_last = COL_W'(2);
    end else if (width_r > WIDTH_CFG_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_r - WIDTH_CFG_W'(1));
    end
    if (height_r < HEIGHT_CFG_W'(3)) begin
      row_last = ROW_W'(2);
    end else if (height_r > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(height_r - HEIGHT_CFG_W'(1));
    end
  end

  // Handshake chain: a stage loads when empty or when it drains
  assign load_o    = !vo_r || out_tready;
  assign load3     = !v3_r || load_o;
  assign load2     = !v2_r || load3;
  assign load1     = !v1_r || load2;
  assign in_tready = load1;
  assign accept    = in_tvalid && load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (load1)  v1_r <= in_tvalid;
      if (load2)  v2_r <= v1_r;
      if (load3)  v3_r <= v2_r;
      if (load_o) vo_r <= v3_r;
    end
  end

  // Position flags and counter advance
  always_comb begin
    last_col          = col_r >= col_last;
    last_row          = row_r >= row_last;
    flags_in.interior = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    flags_in.border   = (row_r == '0) || (col_r == '0) || last_col || last_row;
    flags_in.done     = last_col && last_row;
    if (last_col && last_row) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: hold the pixel while the line memory is read
  always_ff @(posedge clk) begin
    if (accept) begin
      red_s1_r   <= in_tdata[7:0];
      green_s1_r <= in_tdata[15:8];
      blue_s1_r  <= in_tdata[23:16];
      addr_s1_r  <= col_r;
      flags_s1_r <= flags_in;
    end
  end

  // Gray conversion
  assign gray_acc = {8'd0, W_RED}   * {8'd0, red_s1_r}
                  + {8'd0, W_GREEN} * {8'd0, green_s1_r}
                  + {8'd0, W_BLUE}  * {8'd0, blue_s1_r};
  assign gray_s1  = gray_acc[15:8];

  // Line memory: low byte two rows back, high byte one row back
  assign ram_re    = accept;
  assign ram_we    = load2 && v1_r;
  assign ram_wdata = {gray_s1, ram_rdata[RAM_W-1:GRAY_W]};

  gltc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_s1_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (col_r),
    .rd_data (ram_rdata)
  );

  // Window cells: cell 2 takes the new column, cell 0 holds the oldest
  assign cell_ctl.shift    = load2 && v1_r;
  assign cell_ctl.sum_load = load3 && v2_r;
  assign cell_in[TAPS-1]   = {gray_s1, ram_rdata[RAM_W-1:GRAY_W], ram_rdata[GRAY_W-1:0]};

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k < TAPS - 1) begin : g_link
      assign cell_in[k] = cell_out[k+1];
    end
    for (genvar f = 0; f < TAPS; f++) begin : g_coef
      assign cell_coef[k][f] = kernel_r[COEF_W*(f*TAPS+k) +: COEF_W];
    end
    gltc_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .col_in  (cell_in[k]),
      .coefs   (cell_coef[k]),
      .col_out (cell_out[k]),
      .psum    (cell_sum[k])
    );
  end

  // Carry the flags alongside the window
  always_ff @(posedge clk) begin
    if (load2 && v1_r) flags_s2_r <= flags_s1_r;
    if (load3 && v2_r) flags_s3_r <= flags_s2_r;
  end

  // Output stage: total, threshold and black count
  always_comb begin
    edge_sum = {{(EDGE_W-PSUM_W){cell_sum[0][PSUM_W-1]}}, cell_sum[0]}
             + {{(EDGE_W-PSUM_W){cell_sum[1][PSUM_W-1]}}, cell_sum[1]}
             + {{(EDGE_W-PSUM_W){cell_sum[2][PSUM_W-1]}}, cell_sum[2]};
    bin_nxt  = flags_s3_r.interior && (edge_sum > thr_r);
    inc      = {1'b0, flags_s3_r.interior && !bin_nxt}
             + {1'b0, flags_s3_r.border && !thr_r[THR_W-1]};
    cnt_nxt  = black_r + CNT_W'(inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '0;
    end else if (load_o && v3_r) begin
      black_r <= flags_s3_r.done ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o && v3_r) begin
      edge_valid_o_r <= flags_s3_r.interior;
      edge_o_r       <= flags_s3_r.interior ? edge_sum : '0;
      bin_o_r        <= bin_nxt;
      done_o_r       <= flags_s3_r.done;
      count_o_r      <= flags_s3_r.done ? cnt_nxt : '0;
      found_o_r      <= flags_s3_r.done && (cnt_nxt >= obj_r);
    end
  end

  assign out_tvalid = vo_r;
  assign out_tuser  = edge_valid_o_r;
  assign out_tlast  = done_o_r;
  assign out_tdata  = {6'd0, count_o_r, found_o_r, bin_o_r, edge_o_r};

`ifndef SYNTHESIS
  // Edge fields stay clear without an interior result
  a_edge_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[16:0] == '0))
    else $error("edge fields set without edge result");

  // Frame summary only on the last beat of a frame
  a_summary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[41:17] == '0))
    else $error("frame summary set before end of frame");

  // Count restarts after the last pixel of a frame
  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_o && v3_r && flags_s3_r.done) |=> (black_r == '0))
    else $error("black count not cleared at end of frame");

  // Line memory never reads the entry being written
  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (addr_s1_r != col_r))
    else $error("line memory read and write collide");
`endif

endmodule
